### sv/fbfl_pkg.sv
// Shared types, widths and codes for the fixed-size block free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

package fbfl_pkg;

  // Field widths
  localparam int unsigned OFF_W     = 32;  // byte offset on free
  localparam int unsigned BS_W      = 13;  // block size register
  localparam int unsigned NB_W      = 11;  // block count register
  localparam int unsigned TAG_W     = 16;  // version tag
  localparam int unsigned BOFF_W    = 22;  // returned block offset
  localparam int unsigned BIDX_W    = 10;  // returned block index
  localparam int unsigned FC_W      = 11;  // returned free count
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = BS_W;

  // Build-time defaults
  localparam int unsigned DEFAULT_MAX_BLOCKS = 1024;
  localparam int unsigned DEFAULT_PTR_ALIGN  = 8;

  // Register reset values
  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = BS_W'(16);
  localparam logic [NB_W-1:0] NUM_BLOCKS_RST = NB_W'(1024);

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_COUNT = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_BAD_OFF = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 2'd0,
    REG_NUM_BLOCKS = 2'd1
  } reg_e;

  typedef struct packed {
    act_e             action;
    logic [OFF_W-1:0] byte_offset;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [BOFF_W-1:0] block_offset;
    logic [BIDX_W-1:0] block_index;
    logic [FC_W-1:0]   free_count;
    logic [TAG_W-1:0]  version_tag;
  } out_item_t;

  // Divider result toward the sequencer
  typedef struct packed {
    logic             done;
    logic             align_ok;
    logic [OFF_W-1:0] quotient;
    logic [BS_W-1:0]  remainder;
  } div_res_t;

endpackage : fbfl_pkg

`default_nettype wire

### sv/fbfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : fbfl_ram

`default_nettype wire

### sv/fbfl_div.sv
// Bit-serial restoring divider: offset by block size, plus offset modulo the pointer alignment.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_div import fbfl_pkg::*; #(
  parameter int unsigned PTR_ALIGN = DEFAULT_PTR_ALIGN
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [OFF_W-1:0] dividend_i,
  input  wire logic [BS_W-1:0]  divisor_i,
  output div_res_t              res_o
);

  localparam int unsigned CNT_W = $clog2(OFF_W + 1);
  localparam int unsigned AL_W  = $clog2(PTR_ALIGN + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [OFF_W-1:0] dvd_q, dvd_d;
  logic [BS_W-1:0]  rem_q, rem_d;
  logic [AL_W-1:0]  arem_q, arem_d;

  logic [BS_W:0]    trial;
  logic             ge;
  logic [BS_W:0]    diff;
  logic [AL_W:0]    atrial;
  logic             age;
  logic [AL_W:0]    adiff;

  // One quotient bit per cycle, alignment remainder alongside
  always_comb begin
    trial  = {rem_q, dvd_q[OFF_W-1]};
    ge     = trial >= {1'b0, divisor_i};
    diff   = trial - {1'b0, divisor_i};
    atrial = {arem_q, dvd_q[OFF_W-1]};
    age    = atrial >= (AL_W + 1)'(PTR_ALIGN);
    adiff  = atrial - (AL_W + 1)'(PTR_ALIGN);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    arem_d = arem_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(OFF_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      arem_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
      arem_d = age ? adiff[AL_W-1:0] : atrial[AL_W-1:0];
      dvd_d  = {dvd_q[OFF_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath holds no reset
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    arem_q <= arem_d;
  end

  assign res_o.done      = done_q;
  assign res_o.align_ok  = (arem_q == '0);
  assign res_o.quotient  = dvd_q;
  assign res_o.remainder = rem_q;

endmodule : fbfl_div

`default_nettype wire

### sv/fixed_block_free_list_allocator.sv
// Top level: sequencer, free-list state and link memory of the block allocator.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size block allocator with a LIFO free list held in a link memory of
// MAX_BLOCKS entries. One item is worked at a time; the input stalls until
// its result is staged, while a previous result may still wait at the
// output register. Allocate does one registered read of the link memory
// when the list is not empty; free runs the 32-step bit-serial divider
// that turns the byte offset into a block index and checks it; init
// writes one link per cycle on the memory's single write port for the
// active block count. Link memory contents are undefined after reset
// and need no clearing: only links written by init or free are ever read.
module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DEFAULT_MAX_BLOCKS,
  parameter int unsigned PTR_ALIGN  = DEFAULT_PTR_ALIGN
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o
);

  localparam int unsigned LINK_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CMP_W  = (LINK_W > NB_W) ? LINK_W : NB_W;
  localparam int unsigned PROD_W = LINK_W + BS_W;
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_INIT      = 6'b000010,
    ST_ALLOC_RD  = 6'b000100,
    ST_ALLOC_FIN = 6'b001000,
    ST_DIV       = 6'b010000,
    ST_RESP      = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [BS_W-1:0]   bs_q;
  logic [NB_W-1:0]   nb_q;
  logic [LINK_W-1:0] head_q, head_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [LINK_W-1:0] total_q, total_d;
  logic [LINK_W-1:0] walk_q, walk_d;

  status_e           res_status_q, res_status_d;
  logic [BOFF_W-1:0] res_off_q, res_off_d;
  logic [BIDX_W-1:0] res_idx_q, res_idx_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [LINK_W-1:0] n_eff;
  logic              in_xfer;
  logic              can_emit;
  logic [LINK_W-1:0] walk_nxt;
  logic [PROD_W-1:0] prod;
  logic              free_ok;
  logic [ADDR_W-1:0] free_idx;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  logic              div_start;
  div_res_t          div_res;

  // Link memory
  fbfl_ram #(
    .Width (LINK_W),
    .Depth (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Offset divider
  fbfl_div #(
    .PTR_ALIGN (PTR_ALIGN)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.byte_offset),
    .divisor_i  (bs_q),
    .res_o      (div_res)
  );

  // Clamp the configured block count to the built capacity
  assign n_eff = (CMP_W'(nb_q) > CMP_W'(MAX_BLOCKS)) ? END_MARK : LINK_W'(nb_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign div_start  = in_xfer && (in_data_i.action == ACT_FREE);
  assign walk_nxt   = walk_q + LINK_W'(1);
  assign prod       = PROD_W'(head_q) * PROD_W'(bs_q);

  // Free is valid when in range, on a block boundary and aligned
  assign free_ok  = (bs_q != '0) && (div_res.quotient < OFF_W'(n_eff)) &&
                    (div_res.remainder == '0) && div_res.align_ok;
  assign free_idx = div_res.quotient[ADDR_W-1:0];

  // Sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tag_d        = tag_q;
    total_d      = total_q;
    walk_d       = walk_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = walk_q[ADDR_W-1:0];
    ram_wdata    = (walk_nxt == n_eff) ? END_MARK : walk_nxt;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = STATUS_OK;
          res_off_d    = '0;
          res_idx_d    = '0;
          unique case (in_data_i.action)
            ACT_INIT: begin
              if (n_eff == '0) begin
                head_d  = END_MARK;
                tag_d   = '0;
                total_d = '0;
                state_d = ST_RESP;
              end else begin
                walk_d  = '0;
                state_d = ST_INIT;
              end
            end
            ACT_ALLOC: begin
              if ((total_q == '0) || (head_q >= END_MARK)) begin
                res_status_d = STATUS_EMPTY;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_ALLOC_RD;
              end
            end
            ACT_FREE: begin
              state_d = ST_DIV;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // Link block i to block i+1, end mark on the last one
      ST_INIT: begin
        ram_we = 1'b1;
        walk_d = walk_nxt;
        if (walk_nxt == n_eff) begin
          head_d  = '0;
          tag_d   = '0;
          total_d = n_eff;
          state_d = ST_RESP;
        end
      end

      // Wait for the head's link
      ST_ALLOC_RD: begin
        state_d = ST_ALLOC_FIN;
      end

      // Pop the head
      ST_ALLOC_FIN: begin
        head_d    = ram_rdata;
        total_d   = total_q - LINK_W'(1);
        tag_d     = tag_q + TAG_W'(1);
        res_idx_d = BIDX_W'(head_q);
        res_off_d = BOFF_W'(prod);
        state_d   = ST_RESP;
      end

      // Check the offset and push its block
      ST_DIV: begin
        if (div_res.done) begin
          if (free_ok) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = head_q;
            head_d    = LINK_W'(free_idx);
            if (total_q < END_MARK) begin
              total_d = total_q + LINK_W'(1);
            end
            tag_d     = tag_q + TAG_W'(1);
            res_idx_d = BIDX_W'(free_idx);
          end else begin
            res_status_d = STATUS_BAD_OFF;
          end
          state_d = ST_RESP;
        end
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (can_emit) begin
          out_valid_d        = 1'b1;
          out_d.status       = res_status_q;
          out_d.block_offset = res_off_q;
          out_d.block_index  = res_idx_q;
          out_d.free_count   = FC_W'(total_q);
          out_d.version_tag  = tag_q;
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tag_q       <= '0;
      total_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
      bs_q        <= BLOCK_SIZE_RST;
      nb_q        <= NUM_BLOCKS_RST;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tag_q       <= tag_d;
      total_q     <= total_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BLOCK_SIZE: bs_q <= cfg_wdata_i[BS_W-1:0];
          REG_NUM_BLOCKS: nb_q <= cfg_wdata_i[NB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload holds no reset
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_idx_q    <= res_idx_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result only appears right after the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESP))
    else $error("result raised outside the response state");

  // The free counter never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= END_MARK)
    else $error("free counter above capacity");

  // The divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV))
    else $error("divider finished outside a free");

  // A pop bumps the tag and drops the counter by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC_FIN) |=>
      (tag_q == $past(tag_q) + TAG_W'(1)) && (total_q == $past(total_q) - LINK_W'(1)))
    else $error("allocate did not update tag and counter");

endmodule : fixed_block_free_list_allocator

`default_nettype wire

### sim/fbfl_alloc_checker.sv
// Checker for the block allocator: free-list prediction and result comparison.
`timescale 1ns / 1ps

module fbfl_alloc_checker import fbfl_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire in_item_t             in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire out_item_t            out_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int unsigned POOL_CAP  = DEFAULT_MAX_BLOCKS;
  localparam int unsigned ALIGN     = DEFAULT_PTR_ALIGN;
  localparam logic [NB_W-1:0] LIST_END = NB_W'(DEFAULT_MAX_BLOCKS);

  // Shadow of the allocator state and registers
  logic [NB_W-1:0]  link_mem [POOL_CAP];
  logic [NB_W-1:0]  head_idx;
  logic [TAG_W-1:0] mod_tag;
  logic [FC_W-1:0]  free_blocks;
  logic [BS_W-1:0]  blk_size;
  logic [NB_W-1:0]  blk_count;

  out_item_t predicted_replies[$];
  int        mismatches = 0;

  // Work out the reply to one request and advance the shadow state
  task automatic apply_request(input in_item_t req, output out_item_t rep);
    int unsigned       n;
    int unsigned       i;
    int unsigned       idx;
    longint unsigned   span;
    longint unsigned   off;
    logic [63:0]       prod;
    logic [NB_W-1:0]   h;
    n   = (blk_count > POOL_CAP) ? POOL_CAP : blk_count;
    rep = '0;
    rep.status = STATUS_OK;
    case (req.action)
      ACT_INIT: begin
        for (i = 0; i + 1 < n; i++) link_mem[i] = NB_W'(i + 1);
        if (n > 0) begin
          link_mem[n - 1] = LIST_END;
          head_idx = '0;
        end else begin
          head_idx = LIST_END;
        end
        mod_tag     = '0;
        free_blocks = FC_W'(n);
      end
      ACT_ALLOC: begin
        if (free_blocks == 0 || head_idx >= POOL_CAP) begin
          rep.status = STATUS_EMPTY;
        end else begin
          h           = head_idx;
          head_idx    = link_mem[h];
          free_blocks = free_blocks - 1'b1;
          mod_tag     = mod_tag + 1'b1;
          prod        = 64'(h) * blk_size;
          rep.block_index  = h[BIDX_W-1:0];
          rep.block_offset = prod[BOFF_W-1:0];
        end
      end
      ACT_FREE: begin
        span = 64'(n) * blk_size;
        off  = 64'(req.byte_offset);
        if (blk_size == 0 || off >= span || (off % ALIGN) != 0 || (off % blk_size) != 0) begin
          rep.status = STATUS_BAD_OFF;
        end else begin
          idx = int'(off / blk_size);
          link_mem[idx] = head_idx;
          head_idx = NB_W'(idx);
          if (free_blocks < POOL_CAP) free_blocks = free_blocks + 1'b1;
          mod_tag = mod_tag + 1'b1;
          rep.block_index = BIDX_W'(idx);
        end
      end
      default: begin
        // count only reports the kept total
      end
    endcase
    rep.free_count  = free_blocks;
    rep.version_tag = mod_tag;
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Track register writes, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_ni) begin
      head_idx    = '0;
      mod_tag     = '0;
      free_blocks = '0;
      blk_size    = BLOCK_SIZE_RST;
      blk_count   = NUM_BLOCKS_RST;
      predicted_replies.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BLOCK_SIZE: blk_size  = cfg_wdata_i[BS_W-1:0];
          REG_NUM_BLOCKS: blk_count = cfg_wdata_i[NB_W-1:0];
          default: begin
            // unknown index: drop the write
          end
        endcase
      end
      // Compare the oldest prediction first: a reply never leaves with its own request
      if (out_valid_i && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("status", want.status, out_data_i.status);
          check_field("block_offset", want.block_offset, out_data_i.block_offset);
          check_field("block_index", want.block_index, out_data_i.block_index);
          check_field("free_count", want.free_count, out_data_i.free_count);
          check_field("version_tag", want.version_tag, out_data_i.version_tag);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(in_data_i, fresh);
        predicted_replies.push_back(fresh);
      end
    end
    pending_o    = predicted_replies.size();
    fail_count_o = mismatches;
  end

endmodule

### sim/fixed_block_free_list_allocator_tb.sv
// Testbench top for the block allocator: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  localparam int unsigned POOL_CAP     = DEFAULT_MAX_BLOCKS;
  localparam int unsigned ITEM_TARGET  = 1475;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;

  int          fails;
  int          pending;
  int unsigned reqs_sent = 0;
  int unsigned cycle_count;
  int unsigned cur_bs = 16;
  int unsigned cur_n  = POOL_CAP;
  bit          idle_on = 1'b0;
  bit          hold_long = 1'b0;

  fixed_block_free_list_allocator u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  fbfl_alloc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fixed_block_free_list_allocator test failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until the transfer; valid stays high afterwards
  task automatic send_req(input act_e act, input logic [OFF_W-1:0] off);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, byte_offset: off};
    do @(posedge clk); while (in_stall);
    reqs_sent++;
  endtask

  // Drop valid and pause until every reply is back
  task automatic wait_all_replies();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Program both registers back to back, sometimes with a write to an unused index
  task automatic write_regs(input int unsigned bs, input int unsigned nb);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_BLOCK_SIZE;
    cfg_wdata <= bs[BS_W-1:0];
    @(posedge clk);
    cfg_idx   <= REG_NUM_BLOCKS;
    cfg_wdata <= {2'($urandom_range(0, 3)), nb[NB_W-1:0]};
    @(posedge clk);
    if ($urandom_range(0, 3) == 0) begin
      cfg_idx   <= ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_bs = bs;
    cur_n  = (nb > POOL_CAP) ? POOL_CAP : nb;
  endtask

  // Offset of an in-range, aligned block under the current settings (random when there are no blocks or size zero)
  function automatic logic [OFF_W-1:0] good_offset();
    int unsigned stride;
    if (cur_bs == 0 || cur_n == 0) return $urandom;
    if (cur_bs % 8 == 0) stride = 1;
    else if (cur_bs % 4 == 0) stride = 2;
    else if (cur_bs % 2 == 0) stride = 4;
    else stride = 8;
    return OFF_W'(stride * $urandom_range(0, (cur_n - 1) / stride) * cur_bs);
  endfunction

  // Offset that is most likely rejected: past the pool, misaligned or between blocks
  function automatic logic [OFF_W-1:0] bad_offset();
    logic [63:0] span;
    span = 64'(cur_n) * cur_bs;
    case ($urandom_range(0, 4))
      0:       return span[OFF_W-1:0] + cur_bs * $urandom_range(0, 3);
      1:       return good_offset() + $urandom_range(1, 7);
      2:       return good_offset() + 8 * $urandom_range(1, 3);
      3:       return $urandom;
      default: return ~OFF_W'($urandom_range(0, 15));
    endcase
  endfunction

  // One run of requests of a single flavor: pops, pushes, rejects, counts or a mix
  task automatic send_random_run();
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 12);
    repeat (len) begin
      case (kind)
        0, 1, 2, 3: send_req(ACT_ALLOC, $urandom);
        4, 5, 6:    send_req(ACT_FREE, good_offset());
        7:          send_req(ACT_FREE, bad_offset());
        8:          send_req(ACT_COUNT, $urandom);
        default: begin
          pick = $urandom_range(0, 29);
          if (pick == 0) send_req(ACT_INIT, $urandom);
          else if (pick < 10) send_req(ACT_ALLOC, $urandom);
          else if (pick < 19) send_req(ACT_FREE, good_offset());
          else if (pick < 24) send_req(ACT_FREE, bad_offset());
          else send_req(ACT_COUNT, $urandom);
        end
      endcase
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned bs;
    int unsigned nb;
    int unsigned phase_end;
    bit          phase_idle;
    rst_n     = 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_BLOCK_SIZE;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    // Before any init: empty pops, pushes onto the reset head, rejects
    send_req(ACT_COUNT, $urandom);
    send_req(ACT_ALLOC, '0);
    send_req(ACT_FREE, 32);
    send_req(ACT_ALLOC, '0);
    send_req(ACT_ALLOC, '0);
    send_req(ACT_FREE, '1);
    send_req(ACT_FREE, 16 * (POOL_CAP - 1));
    send_req(ACT_FREE, 4);

    // Tiny pool: drain to the end mark, double free, offset at the span edge
    wait_all_replies();
    write_regs(8, 3);
    send_req(ACT_INIT, $urandom);
    repeat (4) send_req(ACT_ALLOC, $urandom);
    send_req(ACT_FREE, 16);
    send_req(ACT_FREE, 16);
    send_req(ACT_FREE, 24);

    // Zero blocks: empty list, every free rejected
    wait_all_replies();
    write_regs(8, 0);
    send_req(ACT_INIT, $urandom);
    send_req(ACT_ALLOC, $urandom);
    send_req(ACT_FREE, '0);

    // Oversized count clamps to capacity; free total saturates
    wait_all_replies();
    write_regs(8, 2047);
    send_req(ACT_INIT, $urandom);
    send_req(ACT_FREE, 8);
    send_req(ACT_ALLOC, $urandom);

    // Zero block size: offset 0 on pop, free rejected
    wait_all_replies();
    write_regs(0, 5);
    send_req(ACT_INIT, $urandom);
    send_req(ACT_ALLOC, $urandom);
    send_req(ACT_FREE, '0);

    // Widest block size
    wait_all_replies();
    write_regs(8191, 9);
    send_req(ACT_INIT, $urandom);
    send_req(ACT_ALLOC, $urandom);
    send_req(ACT_ALLOC, $urandom);
    send_req(ACT_FREE, 8 * 8191);

    // Back-pressure: receiver holds off while requests keep coming
    hold_long = 1'b1;
    repeat (16) send_req(($urandom_range(0, 1) != 0) ? ACT_ALLOC : ACT_COUNT, $urandom);

    // Random phases, each under its own settings and starting from a fresh list
    while (reqs_sent < ITEM_TARGET) begin
      wait_all_replies();
      case ($urandom_range(0, 9))
        0:       bs = ($urandom_range(0, 1) != 0) ? 0 : 8191;
        1:       bs = $urandom_range(2, 7);
        2:       bs = 4096;
        3:       bs = $urandom_range(0, 8191);
        4, 5, 6: bs = 8 * $urandom_range(1, 32);
        default: bs = $urandom_range(2, 100);
      endcase
      case ($urandom_range(0, 11))
        0:       nb = 0;
        1:       nb = 1;
        2:       nb = ($urandom_range(0, 1) != 0) ? POOL_CAP : $urandom_range(POOL_CAP + 1, 2047);
        3:       nb = $urandom_range(0, 2047);
        default: nb = $urandom_range(2, 40);
      endcase
      write_regs(bs, nb);
      phase_idle = ($urandom_range(0, 3) != 0);
      phase_end  = reqs_sent + $urandom_range(40, 90);
      idle_on    = phase_idle && (reqs_sent + CALM_TAIL < ITEM_TARGET);
      send_req(ACT_INIT, $urandom);
      while (reqs_sent < phase_end && reqs_sent < ITEM_TARGET) begin
        idle_on = phase_idle && (reqs_sent + CALM_TAIL < ITEM_TARGET);
        send_random_run();
      end
    end

    // Let the last replies out, then settle
    idle_on = 1'b0;
    wait_all_replies();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("fixed_block_free_list_allocator test passed");
    end else begin
      $display("fixed_block_free_list_allocator test failed");
    end
    $finish;
  end

endmodule
